// ===== rtl/wdc_pkg.sv =====
package wdc_pkg;

	// Fixed field widths
	localparam int CFG_W = 11;
	localparam int PIX_W = 16;
	localparam int OUT_W = 10;

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] DIM_RESET = 11'd512;

	// Controller states, one-hot
	typedef enum logic [7:0] {
		ST_RUN     = 8'b0000_0001,
		ST_FLUSH1  = 8'b0000_0010,
		ST_FLUSH2  = 8'b0000_0100,
		ST_CHECK   = 8'b0000_1000,
		ST_ROW_DIV = 8'b0001_0000,
		ST_COL_DIV = 8'b0010_0000,
		ST_SPARE_A = 8'b0100_0000,
		ST_SPARE_B = 8'b1000_0000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;      // pixel request taken this cycle
		logic div_start;   // load divider
		logic div_col;     // divider dividend: column moment
		logic cap_row;     // latch row quotient
		logic emit_quot;   // present quotients, clear sums
		logic emit_center; // present frame centre, clear sums
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_end;   // current position is the last pixel of the frame
		logic wt_zero;     // weight sum is zero
		logic div_done;    // divider quotient ready
	} status_t;

endpackage

// ===== rtl/wdc_div.sv =====
module wdc_div #(
	parameter int DVD_W = 45,
	parameter int DVS_W = 35,
	parameter int Q_W   = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [Q_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic             active_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] rem_q;
	logic [DVD_W-1:0] dsh_q;
	logic [Q_W-1:0]   quo_q;
	logic             ge;
	logic [DVD_W-1:0] diff;

	// One quotient bit per cycle, restoring
	assign ge   = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(Q_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// Remainder, shifted divisor, quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DVD_W'(divisor) << (Q_W - 1);
			quo_q <= '0;
		end else if (active_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= (quo_q << 1) | Q_W'(ge);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/wdc_dp.sv =====
module wdc_dp #(
	parameter int MAX_DIM   = 1024,
	parameter int FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wdc_pkg::cmd_t                        cmd,
	output wdc_pkg::status_t                     status,
	input  logic signed [wdc_pkg::PIX_W-1:0]     pixel_value,
	input  logic                                 cfg_we,
	input  logic [wdc_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [wdc_pkg::CFG_W-1:0]            cfg_data,
	output logic [wdc_pkg::OUT_W-1:0]            centroid_row,
	output logic [wdc_pkg::OUT_W-1:0]            centroid_col,
	output logic                                 no_weight,
	output logic                                 done
);

	import wdc_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int EW    = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (EW > CFG_W) ? EW : CFG_W;
	localparam int WGT_W = FRAC_BITS + 1;
	localparam int PRD_W = WGT_W + DIM_W;
	localparam int WT_W  = WGT_W + 2 * DIM_W;
	localparam int MOM_W = WT_W + DIM_W;
	localparam int PW    = (FRAC_BITS + 2 > PIX_W) ? FRAC_BITS + 2 : PIX_W;
	localparam logic [PW-1:0] ONE_PW = PW'(1) << FRAC_BITS;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [EW-1:0]    eff_w;
	logic [EW-1:0]    eff_h;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             row_end;
	logic             frame_end;
	logic [PW-1:0]    pix_ext;
	logic [PW-1:0]    pix_diff;
	logic [WGT_W-1:0] wgt;

	logic             valid_s1;
	logic [WGT_W-1:0] wgt_s1;
	logic [DIM_W-1:0] row_s1;
	logic [DIM_W-1:0] col_s1;
	logic             valid_s2;
	logic [WGT_W-1:0] wgt_s2;
	logic [PRD_W-1:0] prod_r_s2;
	logic [PRD_W-1:0] prod_c_s2;

	logic [WT_W-1:0]  wt_q;
	logic [MOM_W-1:0] rowm_q;
	logic [MOM_W-1:0] colm_q;

	logic             div_done;
	logic [DIM_W-1:0] quot;
	logic [OUT_W+DIM_W-1:0] quot_ext;
	logic [OUT_W+EW-1:0]    half_w_ext;
	logic [OUT_W+EW-1:0]    half_h_ext;

	logic [OUT_W-1:0] row_out_q;
	logic [OUT_W-1:0] col_out_q;
	logic             nw_q;
	logic             done_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective dimensions, clamped to 1..MAX_DIM
	always_comb begin
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if (CMP_W'(width_q) > CMP_W'(MAX_DIM)) begin
			eff_w = EW'(MAX_DIM);
		end else begin
			eff_w = EW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = EW'(1);
		end else if (CMP_W'(height_q) > CMP_W'(MAX_DIM)) begin
			eff_h = EW'(MAX_DIM);
		end else begin
			eff_h = EW'(height_q);
		end
	end

	// Raster position
	assign row_end   = EW'(col_q) >= eff_w - EW'(1);
	assign frame_end = row_end && (EW'(row_q) >= eff_h - EW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_q + DIM_W'(1);
			end
		end
	end

	// Darkness weight: zero for negative or saturated pixels
	assign pix_ext  = PW'(pixel_value[PIX_W-2:0]);
	assign pix_diff = ONE_PW - pix_ext;
	assign wgt = (pixel_value[PIX_W-1] || (pix_ext > ONE_PW)) ? '0 : pix_diff[WGT_W-1:0];

	// Stage 1: weight and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		wgt_s1 <= wgt;
		row_s1 <= row_q;
		col_s1 <= col_q;
	end

	// Stage 2: moment products
	always_ff @(posedge clk) begin
		wgt_s2    <= wgt_s1;
		prod_r_s2 <= PRD_W'(wgt_s1) * PRD_W'(row_s1);
		prod_c_s2 <= PRD_W'(wgt_s1) * PRD_W'(col_s1);
	end

	// Exact running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_q   <= '0;
			rowm_q <= '0;
			colm_q <= '0;
		end else if (cmd.emit_quot || cmd.emit_center) begin
			wt_q   <= '0;
			rowm_q <= '0;
			colm_q <= '0;
		end else if (valid_s2) begin
			wt_q   <= wt_q + WT_W'(wgt_s2);
			rowm_q <= rowm_q + MOM_W'(prod_r_s2);
			colm_q <= colm_q + MOM_W'(prod_c_s2);
		end
	end

	// Shared divider for both moments
	wdc_div #(
		.DVD_W(MOM_W),
		.DVS_W(WT_W),
		.Q_W  (DIM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(cmd.div_col ? colm_q : rowm_q),
		.divisor (wt_q),
		.done    (div_done),
		.quotient(quot)
	);

	assign quot_ext   = (OUT_W + DIM_W)'(quot);
	assign half_w_ext = (OUT_W + EW)'(eff_w >> 1);
	assign half_h_ext = (OUT_W + EW)'(eff_h >> 1);

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_quot || cmd.emit_center;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_row) begin
			row_out_q <= quot_ext[OUT_W-1:0];
		end else if (cmd.emit_center) begin
			row_out_q <= half_h_ext[OUT_W-1:0];
		end
		if (cmd.emit_quot) begin
			col_out_q <= quot_ext[OUT_W-1:0];
			nw_q      <= 1'b0;
		end else if (cmd.emit_center) begin
			col_out_q <= half_w_ext[OUT_W-1:0];
			nw_q      <= 1'b1;
		end
	end

	assign status.frame_end = frame_end;
	assign status.wt_zero   = (wt_q == '0);
	assign status.div_done  = div_done;

	assign centroid_row = row_out_q;
	assign centroid_col = col_out_q;
	assign no_weight    = nw_q;
	assign done         = done_q;

endmodule

// ===== rtl/wdc_ctrl.sv =====
module wdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  wdc_pkg::status_t status,
	output wdc_pkg::cmd_t    cmd
);

	import wdc_pkg::*;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_RUN: begin
				cmd.accept = start;
				if (start && status.frame_end) begin
					state_d = ST_FLUSH1;
				end
			end
			ST_FLUSH1: begin
				state_d = ST_FLUSH2;
			end
			ST_FLUSH2: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.wt_zero) begin
					cmd.emit_center = 1'b1;
					state_d         = ST_RUN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_ROW_DIV;
				end
			end
			ST_ROW_DIV: begin
				if (status.div_done) begin
					cmd.cap_row   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_col   = 1'b1;
					state_d       = ST_COL_DIV;
				end
			end
			ST_COL_DIV: begin
				if (status.div_done) begin
					cmd.emit_quot = 1'b1;
					state_d       = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_RUN);

endmodule

// ===== rtl/weighted_dark_centroid.sv =====
// Darkness-weighted centroid of one frame. Pixels stream in raster order, one
// request per cycle while busy is low. After the last pixel of a frame busy
// stays high through the flush states FLUSH1 and FLUSH2, the check state and
// the shared restoring divider, which produces one quotient bit per cycle,
// first for the row moment and then for the column moment; a frame with zero
// total weight skips the divider. The result appears on centroid_row,
// centroid_col and no_weight for exactly one cycle with done high; it is not
// held, so the receiver must take it in that cycle.
// Frame size registers are meant to be written between frames.
module weighted_dark_centroid #(
	parameter int MAX_DIM   = 1024,
	parameter int FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [wdc_pkg::PIX_W-1:0]    pixel_value,
	input  logic                                cfg_we,
	input  logic [wdc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [wdc_pkg::CFG_W-1:0]           cfg_data,
	output logic                                done,
	output logic [wdc_pkg::OUT_W-1:0]           centroid_row,
	output logic [wdc_pkg::OUT_W-1:0]           centroid_col,
	output logic                                no_weight
);

	import wdc_pkg::*;

	cmd_t    cmd;
	status_t status;

	wdc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.status(status),
		.cmd   (cmd)
	);

	wdc_dp #(
		.MAX_DIM  (MAX_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.pixel_value (pixel_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.centroid_row(centroid_row),
		.centroid_col(centroid_col),
		.no_weight   (no_weight),
		.done        (done)
	);

endmodule

// ===== rtl/wdc_checker.sv =====
module wdc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result comes out as the block returns to taking pixels
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// The result is computed during a busy interval
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding busy interval");

	// One result per frame, never on consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// Busy only begins on a taken pixel request
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a pixel request");

endmodule

bind weighted_dark_centroid wdc_checker u_wdc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

// ===== dv/wdc_centroid_checker.sv =====
`timescale 1ns / 1ps

// Watches the pixel, register and result ports of weighted_dark_centroid,
// keeps its own copy of the frame sums and flags every result that differs.
module wdc_centroid_checker #(
	parameter int MAX_DIM   = 1024,
	parameter int FRAC_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic signed [wdc_pkg::PIX_W-1:0] pixel_value,
	input  logic                             cfg_we,
	input  logic [wdc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [wdc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             done,
	input  logic [wdc_pkg::OUT_W-1:0]        centroid_row,
	input  logic [wdc_pkg::OUT_W-1:0]        centroid_col,
	input  logic                             no_weight,
	output int                               errors,
	output int                               pending,
	output int                               centroids,
	output int                               centre_hits
);
	import wdc_pkg::*;

	localparam int ONE = 1 << FRAC_BITS;

	typedef struct packed {
		logic [OUT_W-1:0] row;
		logic [OUT_W-1:0] col;
		logic             centre;
	} centroid_t;

	// Register copies and running frame sums
	logic [CFG_W-1:0] width_reg, height_reg;
	logic [OUT_W-1:0] next_row, next_col;
	logic [34:0]      dark_total;
	logic [44:0]      row_weighted, col_weighted;
	centroid_t        centroid_q[$];
	int               err_cnt, seen_cnt, centre_cnt;

	// Size register as the block uses it: 0 acts as 1, large values clamp
	function automatic int clamp_dim(input logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int        w_eff, h_eff, pix, dark;
		centroid_t want;
		if (!arst_n) begin
			width_reg    = DIM_RESET;
			height_reg   = DIM_RESET;
			next_row     = '0;
			next_col     = '0;
			dark_total   = '0;
			row_weighted = '0;
			col_weighted = '0;
			centroid_q.delete();
			err_cnt      = 0;
			seen_cnt     = 0;
			centre_cnt   = 0;
		end else begin
			// Result strobe against the oldest prediction
			if (done) begin
				seen_cnt++;
				if (no_weight) centre_cnt++;
				if (centroid_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result with none expected: row %0d col %0d no_weight %0b",
						$time, centroid_row, centroid_col, no_weight);
				end else begin
					want = centroid_q.pop_front();
					if (centroid_row !== want.row) begin
						err_cnt++;
						$display("%0t: centroid_row expected %0d, got %0d",
							$time, want.row, centroid_row);
					end
					if (centroid_col !== want.col) begin
						err_cnt++;
						$display("%0t: centroid_col expected %0d, got %0d",
							$time, want.col, centroid_col);
					end
					if (no_weight !== want.centre) begin
						err_cnt++;
						$display("%0t: no_weight expected %0b, got %0b",
							$time, want.centre, no_weight);
					end
				end
			end

			// Accepted pixel request: accumulate, then step the raster position
			if (start && !busy) begin
				w_eff = clamp_dim(width_reg);
				h_eff = clamp_dim(height_reg);
				pix   = int'(pixel_value);
				if (pix >= 0) begin
					dark = (pix > ONE) ? 0 : ONE - pix;
					dark_total   += 35'(dark);
					row_weighted += 45'(dark) * 45'(next_row);
					col_weighted += 45'(dark) * 45'(next_col);
				end
				if (int'(next_col) >= w_eff - 1) begin
					if (int'(next_row) >= h_eff - 1) begin
						// last pixel of the frame
						if (dark_total == 0) begin
							want.row    = OUT_W'(h_eff / 2);
							want.col    = OUT_W'(w_eff / 2);
							want.centre = 1'b1;
						end else begin
							want.row    = OUT_W'(row_weighted / dark_total);
							want.col    = OUT_W'(col_weighted / dark_total);
							want.centre = 1'b0;
						end
						centroid_q.push_back(want);
						next_row     = '0;
						next_col     = '0;
						dark_total   = '0;
						row_weighted = '0;
						col_weighted = '0;
					end else begin
						next_col = '0;
						next_row++;
					end
				end else begin
					next_col++;
				end
			end

			// Register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  width_reg  = cfg_data;
					REG_FRAME_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
		end
		errors      <= err_cnt;
		pending     <= centroid_q.size();
		centroids   <= seen_cnt;
		centre_hits <= centre_cnt;
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import wdc_pkg::*;

	localparam int MAX_DIM     = 1024;
	localparam int ITEMS       = 1700;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN       = 40;
	localparam logic signed [PIX_W-1:0] PIX_ONE = 16'sd16384;

	typedef enum int {FRAME_MIXED, FRAME_SPARSE, FRAME_BLANK} frame_kind_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    start       = 1'b0;
	logic signed [PIX_W-1:0] pixel_value = '0;
	logic                    cfg_we      = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index   = '0;
	logic [CFG_W-1:0]        cfg_data    = '0;
	logic                    busy, done, no_weight;
	logic [OUT_W-1:0]        centroid_row, centroid_col;

	int errors, pending, centroids, centre_hits;
	int pixels_sent, sizes_used, burst_left, quiet_cycles;
	int cur_w, cur_h;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	weighted_dark_centroid DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel_value  (pixel_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.centroid_row (centroid_row),
		.centroid_col (centroid_col),
		.no_weight    (no_weight)
	);

	wdc_centroid_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel_value  (pixel_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.centroid_row (centroid_row),
		.centroid_col (centroid_col),
		.no_weight    (no_weight),
		.errors       (errors),
		.pending      (pending),
		.centroids    (centroids),
		.centre_hits  (centre_hits)
	);

	// Watchdog: no request taken and no result for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no progress for %0d cycles", $time, STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int eff_dim(input int v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic logic signed [PIX_W-1:0] pick_pixel(input frame_kind_t kind);
		logic signed [PIX_W-1:0] p;
		int                      r;
		r = int'($urandom_range(0, 15));
		p = PIX_W'($urandom_range(0, 16384));
		case (kind)
			FRAME_BLANK: begin
				// zero weight only: white, above one, or negative
				if (r < 6) p = PIX_ONE;
				else if (r < 11) p = PIX_W'($urandom_range(16385, 32767));
				else begin
					p = PIX_W'($urandom);
					p[PIX_W-1] = 1'b1;
				end
			end
			FRAME_SPARSE: if (r != 0) p = PIX_ONE;
			default: begin
				if (r == 0) begin
					p = PIX_W'($urandom);
					p[PIX_W-1] = 1'b1;
				end else if (r == 1) p = PIX_W'($urandom_range(16385, 32767));
				else if (r == 2) p = PIX_ONE;
				else if (r == 3) p = '0;
			end
		endcase
		return p;
	endfunction

	// One pixel request, sent in bursts with random gaps between them
	task automatic send_pixel(input logic signed [PIX_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start       <= 1'b1;
		pixel_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
		pixels_sent++;
	endtask

	// Drop start, wait out all predicted results, then a further drain interval
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_w = eff_dim(int'(w));
		cur_h = eff_dim(int'(h));
		sizes_used++;
	endtask

	initial begin
		int          phase, frames;
		frame_kind_t kind;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pixel extremes in a 3x2 frame, dark pixels on the second row
		set_size(11'd3, 11'd2);
		send_pixel(PIX_ONE);
		send_pixel(16'shC000);
		send_pixel(16'sh8000);
		send_pixel(16'sd0);
		send_pixel(16'sd8191);
		send_pixel(16'sd1);
		// Frame with no weight at all: centre expected
		send_pixel(PIX_ONE);
		send_pixel(16'sd16385);
		send_pixel(16'sh7FFF);
		send_pixel(16'shFFFF);
		send_pixel(16'sh8000);
		send_pixel(PIX_ONE);

		// Zero sizes clamp to a single pixel per frame
		settle();
		set_size(11'd0, 11'd0);
		send_pixel(16'sd0);
		send_pixel(PIX_ONE);
		send_pixel(16'sd16383);

		// Size change inside a frame: column already past the new width,
		// then the height shrinks below the current row
		settle();
		set_size(11'd8, 11'd3);
		repeat (5) send_pixel(pick_pixel(FRAME_MIXED));
		settle();
		set_size(11'd4, 11'd3);
		repeat (4) send_pixel(pick_pixel(FRAME_MIXED));
		settle();
		set_size(11'd4, 11'd1);
		repeat (4) send_pixel(pick_pixel(FRAME_MIXED));

		// Random frames: mostly small sizes, one at the clamp limits
		phase = 0;
		while (pixels_sent < ITEMS) begin
			settle();
			case (phase)
				2: set_size(11'd2047, 11'd0);
				default: begin
					case ($urandom_range(0, 5))
						0: set_size(CFG_W'($urandom_range(9, 40)),
							CFG_W'($urandom_range(1, 4)));
						1: set_size(CFG_W'($urandom_range(1, 4)),
							CFG_W'($urandom_range(9, 40)));
						default: set_size(CFG_W'($urandom_range(1, 8)),
							CFG_W'($urandom_range(1, 8)));
					endcase
				end
			endcase
			frames = (cur_w * cur_h > 64) ? 1 : $urandom_range(1, 6);
			repeat (frames) begin
				case ($urandom_range(0, 9))
					0: kind = FRAME_BLANK;
					1, 2: kind = FRAME_SPARSE;
					default: kind = FRAME_MIXED;
				endcase
				repeat (cur_w * cur_h) send_pixel(pick_pixel(kind));
			end
			phase++;
		end

		settle();
		$display("%0d pixels over %0d size settings; %0d centroids, %0d of them frame centres",
			pixels_sent, sizes_used, centroids, centre_hits);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/wdc_pkg.sv
rtl/wdc_div.sv
rtl/wdc_dp.sv
rtl/wdc_ctrl.sv
rtl/weighted_dark_centroid.sv
rtl/wdc_checker.sv
dv/wdc_centroid_checker.sv
dv/tb.sv
